>>> hw/rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants for the cubic Hermite spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package chs_pkg;
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_POS   = 2'd1,
        OP_TAN   = 2'd2,
        OP_ACC   = 2'd3
    } op_t;

    localparam int unsigned VEC_W  = 32;
    localparam int unsigned NODE_W = 6 * VEC_W;
    localparam int unsigned WGT_W  = 28;

    typedef struct packed {
        logic signed [WGT_W-1:0] w0;
        logic signed [WGT_W-1:0] w1;
        logic signed [WGT_W-1:0] w2;
        logic signed [WGT_W-1:0] w3;
    } weights_t;

    typedef logic signed [VEC_W-1:0] vec_t;
endpackage
`default_nettype wire

>>> hw/rtl/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/chs_blend.sv
// ----------------------------------------------------------------------------
// chs_blend
// One axis: weighted sum of two endpoints and two tangents, round to Q16.16, saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_blend
    import chs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en_mul,
    input  wire logic      en_sum,
    input  wire weights_t  w,
    input  wire vec_t      p0,
    input  wire vec_t      p1,
    input  wire vec_t      d0,
    input  wire vec_t      d1,
    output vec_t           res
);
    logic signed [59:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [61:0] acc;
    logic signed [61:0] rnd;
    logic signed [37:0] sh;
    vec_t               res_reg;
    vec_t               res_next;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            m0_reg <= 60'(w.w0 * p0);
            m1_reg <= 60'(w.w1 * p1);
            m2_reg <= 60'(w.w2 * d0);
            m3_reg <= 60'(w.w3 * d1);
        end
        if (en_sum)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        acc = 62'(m0_reg) + 62'(m1_reg) + 62'(m2_reg) + 62'(m3_reg);
        rnd = acc + 62'sd8388608;
        sh  = 38'(rnd >>> 24);
        if (sh > 38'sh7FFFFFFF)
        begin
            res_next = 32'sh7FFFFFFF;
        end
        else if (sh < -38'sh80000000)
        begin
            res_next = 32'sh80000000;
        end
        else
        begin
            res_next = sh[31:0];
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

>>> hw/rtl/cubic_hermite_spline_eval.sv
// ----------------------------------------------------------------------------
// cubic_hermite_spline_eval
// Stages: accept, node RAM read, endpoints, weights, products, registered sum.
// Throughput: one request per cycle; an output stall holds the whole pipeline.
// Node store: even/odd RAM banks with registered read data, so both segment
// endpoints are read together; a node write lands at its accepting edge.
// Reset clears all node valid bits and pipeline valids; node data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module cubic_hermite_spline_eval
    import chs_pkg::*;
#(
    parameter int unsigned NODE_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [5:0]  node_index,
    input  wire logic [16:0] t_param,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic [31:0] tan_x,
    input  wire logic [31:0] tan_y,
    input  wire logic [31:0] tan_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      res_x,
    output logic [31:0]      res_y,
    output logic [31:0]      res_z,
    output logic             status
);
    localparam int unsigned IW    = (NODE_DEPTH > 64) ? $clog2(NODE_DEPTH) : 7;
    localparam int unsigned BANK  = (NODE_DEPTH + 1) / 2;
    localparam int unsigned BW    = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int unsigned VW    = $clog2(NODE_DEPTH);

    // pipeline: s0 accept, s1 ram read, s2 endpoints, s3 weights, s4 products, out sum
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [NODE_DEPTH-1:0] valid_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic acc_in;
    assign acc_in = in_valid && in_ready;

    logic [IW-1:0] idx;
    logic [IW-1:0] idx1;
    assign idx  = IW'(node_index);
    assign idx1 = idx + IW'(1);

    logic wr_ok;
    assign wr_ok = acc_in && (op_t'(opcode) == OP_WRITE) && (idx < IW'(NODE_DEPTH));

    // even/odd banks
    logic [BW-1:0] ev_raddr, od_raddr, waddr;
    logic          widx_odd;
    assign waddr    = BW'(idx >> 1);
    assign widx_odd = idx[0];
    assign ev_raddr = BW'((idx + IW'(idx[0])) >> 1);
    assign od_raddr = BW'(idx >> 1);

    logic [NODE_W-1:0] wdata, ev_rdata, od_rdata;
    assign wdata = {pos_x, pos_y, pos_z, tan_x, tan_y, tan_z};

    chs_ram #(.WIDTH(NODE_W), .DEPTH(BANK)) u_even (
        .clk(clk), .we(wr_ok && !widx_odd), .waddr(waddr), .wdata(wdata),
        .re(adv), .raddr(ev_raddr), .rdata(ev_rdata));
    chs_ram #(.WIDTH(NODE_W), .DEPTH(BANK)) u_odd (
        .clk(clk), .we(wr_ok && widx_odd), .waddr(waddr), .wdata(wdata),
        .re(adv), .raddr(od_raddr), .rdata(od_rdata));

    // stage 1 registers
    logic        ev1_reg;
    logic        err1_reg;
    logic [1:0]  op1_reg;
    logic [16:0] t1_reg;
    logic        odd1_reg;
    logic        seg_ok;

    always_comb
    begin
        seg_ok = 1'b0;
        if (idx1 < IW'(NODE_DEPTH))
        begin
            seg_ok = valid_reg[VW'(idx)] && valid_reg[VW'(idx1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[VW'(idx)] <= 1'b1;
            end
            if (adv)
            begin
                v1_reg    <= acc_in;
                v2_reg    <= v1_reg;
                v3_reg    <= v2_reg;
                v4_reg    <= v3_reg;
                out_valid <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= opcode;
            t1_reg   <= (t_param > 17'd65536) ? 17'd65536 : t_param;
            odd1_reg <= idx[0];
            ev1_reg  <= (op_t'(opcode) != OP_WRITE);
            if (op_t'(opcode) == OP_WRITE)
            begin
                err1_reg <= !(idx < IW'(NODE_DEPTH));
            end
            else
            begin
                err1_reg <= !seg_ok;
            end
        end
    end

    // stage 2: endpoints, t and t^2
    vec_t p0x, p0y, p0z, d0x, d0y, d0z, p1x, p1y, p1z, d1x, d1y, d1z;
    assign {p0x, p0y, p0z, d0x, d0y, d0z} = odd1_reg ? od_rdata : ev_rdata;
    assign {p1x, p1y, p1z, d1x, d1y, d1z} = odd1_reg ? ev_rdata : od_rdata;

    logic signed [18:0] ts;
    logic signed [35:0] t2;
    logic               zero1;
    assign ts    = 19'(t1_reg);
    assign t2    = 36'(ts * ts);
    assign zero1 = err1_reg || !ev1_reg;

    vec_t     n_reg [12];
    logic [1:0]  op2_reg;
    logic signed [18:0] t2s_reg;
    logic signed [35:0] tt_reg;
    logic        zero2_reg, err2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]  <= p0x; n_reg[1]  <= p1x; n_reg[2]  <= d0x; n_reg[3]  <= d1x;
            n_reg[4]  <= p0y; n_reg[5]  <= p1y; n_reg[6]  <= d0y; n_reg[7]  <= d1y;
            n_reg[8]  <= p0z; n_reg[9]  <= p1z; n_reg[10] <= d0z; n_reg[11] <= d1z;
            op2_reg   <= op1_reg;
            t2s_reg   <= ts;
            tt_reg    <= t2;
            zero2_reg <= zero1;
            err2_reg  <= err1_reg;
        end
    end

    // stage 3: weights (t^3 via one multiply) then registered
    logic signed [55:0] t3;
    logic signed [68:0] a0, a1, a2, a3;
    logic signed [68:0] t1q, t2q, one;
    weights_t wt, w3_reg;
    logic err3_reg;

    function automatic logic signed [WGT_W-1:0] rs(input logic signed [68:0] v,
                                                  input int unsigned sh);
        logic signed [68:0] r;
        r = (v + (69'sd1 <<< (sh - 1))) >>> sh;
        return r[WGT_W-1:0];
    endfunction

    always_comb
    begin
        t3  = 56'(tt_reg * t2s_reg);
        t1q = 69'(t2s_reg);
        t2q = 69'(tt_reg);
        a0 = '0; a1 = '0; a2 = '0; a3 = '0;
        wt = '0;
        case (op_t'(op2_reg))
            OP_POS:
            begin
                one = 69'sd1 <<< 48;
                a0 = 2 * 69'(t3) - 3 * (t2q <<< 16) + one;
                a1 = -2 * 69'(t3) + 3 * (t2q <<< 16);
                a2 = 69'(t3) - 2 * (t2q <<< 16) + (t1q <<< 32);
                a3 = 69'(t3) - (t2q <<< 16);
                wt.w0 = rs(a0, 24); wt.w1 = rs(a1, 24);
                wt.w2 = rs(a2, 24); wt.w3 = rs(a3, 24);
            end
            OP_TAN:
            begin
                one = 69'sd1 <<< 32;
                a0 = 6 * t2q - 6 * (t1q <<< 16);
                a1 = -6 * t2q + 6 * (t1q <<< 16);
                a2 = 3 * t2q - 4 * (t1q <<< 16) + one;
                a3 = 3 * t2q - 2 * (t1q <<< 16);
                wt.w0 = rs(a0, 8); wt.w1 = rs(a1, 8);
                wt.w2 = rs(a2, 8); wt.w3 = rs(a3, 8);
            end
            OP_ACC:
            begin
                one = 69'sd65536;
                a0 = (12 * t1q - 6 * one) <<< 8;
                a1 = (-12 * t1q + 6 * one) <<< 8;
                a2 = (6 * t1q - 4 * one) <<< 8;
                a3 = (6 * t1q - 2 * one) <<< 8;
                wt.w0 = a0[WGT_W-1:0]; wt.w1 = a1[WGT_W-1:0];
                wt.w2 = a2[WGT_W-1:0]; wt.w3 = a3[WGT_W-1:0];
            end
            default:
            begin
                one = '0;
            end
        endcase
        if (zero2_reg)
        begin
            wt = '0;
        end
    end

    vec_t n3_reg [12];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w3_reg    <= wt;
            n3_reg    <= n_reg;
            err3_reg  <= err2_reg;
        end
    end

    logic err4_reg, err5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err4_reg <= err3_reg;
            err5_reg <= err4_reg;
        end
    end

    vec_t rx, ry, rz;
    chs_blend u_bx (.clk(clk), .en_mul(adv), .en_sum(adv), .w(w3_reg),
        .p0(n3_reg[0]), .p1(n3_reg[1]), .d0(n3_reg[2]), .d1(n3_reg[3]), .res(rx));
    chs_blend u_by (.clk(clk), .en_mul(adv), .en_sum(adv), .w(w3_reg),
        .p0(n3_reg[4]), .p1(n3_reg[5]), .d0(n3_reg[6]), .d1(n3_reg[7]), .res(ry));
    chs_blend u_bz (.clk(clk), .en_mul(adv), .en_sum(adv), .w(w3_reg),
        .p0(n3_reg[8]), .p1(n3_reg[9]), .d0(n3_reg[10]), .d1(n3_reg[11]), .res(rz));

    assign res_x  = rx;
    assign res_y  = ry;
    assign res_z  = rz;
    assign status = err5_reg;
endmodule
`default_nettype wire

>>> hw/rtl/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] res_x,
    input wire logic        status
);
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled while output free");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_x) && $stable(status))
        else $error("result dropped while stalled");
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("ready under stall");
endmodule

bind cubic_hermite_spline_eval chs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .res_x(res_x), .status(status));
`default_nettype wire

>>> dv/tb_cubic_hermite_spline_eval.sv
// ----------------------------------------------------------------------------
// Cubic Hermite spline evaluator testbench
// Drives node writes and position, tangent and acceleration evaluations
// through the request channel and checks every result against an in-bench
// fixed-point predictor of the node table and the Hermite basis.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_cubic_hermite_spline_eval;
    import chs_pkg::*;

    localparam int DEPTH = 64;
    localparam longint MAX_CYCLES = 400000;

    typedef struct {
        op_t         op;
        logic [5:0]  idx;
        logic [16:0] t;
        logic [31:0] p [3];
        logic [31:0] d [3];
        bit          known;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic        st;
    } request_t;

    typedef struct {
        logic [31:0] r [3];
        logic        st;
    } vector_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = '0;
    logic [5:0] node_index = '0;
    logic [16:0] t_param = '0;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [31:0] tan_x = '0, tan_y = '0, tan_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] res_x, res_y, res_z;
    logic status;

    logic [31:0] tbl_pos [DEPTH][3];
    logic [31:0] tbl_tan [DEPTH][3];
    bit tbl_valid [DEPTH];
    vector_result_t pending_results [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycles = 0;
    request_t directed [$];

    cubic_hermite_spline_eval dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .node_index(node_index), .t_param(t_param),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_x(res_x), .res_y(res_y), .res_z(res_z), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [31:0] blend_sat(longint w [4], logic [31:0] a,
                                              logic [31:0] b, logic [31:0] c,
                                              logic [31:0] e);
        longint acc;
        acc = w[0] * longint'($signed(a)) + w[1] * longint'($signed(b))
            + w[2] * longint'($signed(c)) + w[3] * longint'($signed(e));
        acc = rnd_shift(acc, 24);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic vector_result_t predict_spline(request_t rq);
        vector_result_t res;
        longint w [4];
        longint t, t2, t3, t2s;
        int i;
        res.r[0] = '0; res.r[1] = '0; res.r[2] = '0; res.st = 1'b0;
        i = int'(rq.idx);
        if (rq.op == OP_WRITE)
        begin
            tbl_pos[i] = rq.p;
            tbl_tan[i] = rq.d;
            tbl_valid[i] = 1'b1;
            return res;
        end
        if (i + 1 >= DEPTH || !tbl_valid[i] || !tbl_valid[i+1])
        begin
            res.st = 1'b1;
            return res;
        end
        t = (rq.t > 17'd65536) ? longint'(65536) : longint'(rq.t);
        t2 = t * t;
        case (rq.op)
            OP_POS:
            begin
                t3 = t2 * t;
                t2s = t2 * 65536;
                w[0] = rnd_shift(2 * t3 - 3 * t2s + (longint'(1) <<< 48), 24);
                w[1] = rnd_shift(-2 * t3 + 3 * t2s, 24);
                w[2] = rnd_shift(t3 - 2 * t2s + t * (longint'(1) <<< 32), 24);
                w[3] = rnd_shift(t3 - t2s, 24);
            end
            OP_TAN:
            begin
                w[0] = rnd_shift(6 * t2 - 6 * t * 65536, 8);
                w[1] = rnd_shift(-6 * t2 + 6 * t * 65536, 8);
                w[2] = rnd_shift(3 * t2 - 4 * t * 65536 + (longint'(1) <<< 32), 8);
                w[3] = rnd_shift(3 * t2 - 2 * t * 65536, 8);
            end
            default:
            begin
                w[0] = (12 * t - 6 * 65536) * 256;
                w[1] = (-12 * t + 6 * 65536) * 256;
                w[2] = (6 * t - 4 * 65536) * 256;
                w[3] = (6 * t - 2 * 65536) * 256;
            end
        endcase
        for (int k = 0; k < 3; k++)
            res.r[k] = blend_sat(w, tbl_pos[i][k], tbl_pos[i+1][k],
                                 tbl_tan[i][k], tbl_tan[i+1][k]);
        return res;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 2000000))
                                           : 32'($urandom_range(0, 2000000));
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t node_write(int i, logic [31:0] v);
        request_t rq;
        rq.op = OP_WRITE; rq.idx = 6'(i); rq.t = 17'($urandom);
        for (int k = 0; k < 3; k++)
        begin
            rq.p[k] = (v === 'x) ? rnd_word() : v;
            rq.d[k] = (v === 'x) ? rnd_word() : v;
        end
        rq.known = 1'b0;
        return rq;
    endfunction

    function automatic request_t eval_req(op_t op, int i, logic [16:0] t);
        request_t rq;
        rq = node_write(i, '0);
        rq.op = op; rq.t = t;
        for (int k = 0; k < 3; k++)
        begin
            rq.p[k] = $urandom;
            rq.d[k] = $urandom;
        end
        return rq;
    endfunction

    function automatic request_t with_result(request_t rq, logic [31:0] v,
                                             logic st);
        rq.known = 1'b1;
        rq.rx = v; rq.ry = v; rq.rz = v; rq.st = st;
        return rq;
    endfunction

    task automatic send_request(request_t rq);
        vector_result_t res;
        bit idle;
        idle = (send_idle > 0 && $urandom_range(0, 99) < send_idle);
        if (idle)
            in_valid <= 1'b0;
        while (idle)
        begin
            @(posedge clk);
            idle = ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        opcode <= rq.op; node_index <= rq.idx; t_param <= rq.t;
        pos_x <= rq.p[0]; pos_y <= rq.p[1]; pos_z <= rq.p[2];
        tan_x <= rq.d[0]; tan_y <= rq.d[1]; tan_z <= rq.d[2];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        res = predict_spline(rq);
        if (rq.known)
        begin
            if (rq.rx !== res.r[0] || rq.ry !== res.r[1] || rq.rz !== res.r[2]
                || rq.st !== res.st)
            begin
                errors++;
                if (errors <= 10)
                    $display("table row mismatch: op %0d idx %0d exp %h %h %h %b pred %h %h %h %b",
                             rq.op, rq.idx, rq.rx, rq.ry, rq.rz, rq.st,
                             res.r[0], res.r[1], res.r[2], res.st);
            end
            res.r[0] = rq.rx; res.r[1] = rq.ry; res.r[2] = rq.rz; res.st = rq.st;
        end
        pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= !(recv_idle > 0 && $urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        vector_result_t exp_res;
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("cubic_hermite_spline_eval regression: fail");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (res_x !== exp_res.r[0] || res_y !== exp_res.r[1]
                    || res_z !== exp_res.r[2] || status !== exp_res.st)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                                 exp_res.r[0], exp_res.r[1], exp_res.r[2], exp_res.st,
                                 res_x, res_y, res_z, status);
                end
            end
        end
    end

    initial
    begin
        request_t rq;
        int base;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(with_result(eval_req(OP_POS, 0, 17'd0), '0, 1'b1));
        directed.push_back(with_result(node_write(0, 32'h7fffffff), '0, 1'b0));
        directed.push_back(with_result(eval_req(OP_TAN, 0, 17'd65536), '0, 1'b1));
        directed.push_back(with_result(node_write(1, 32'h80000000), '0, 1'b0));
        directed.push_back(eval_req(OP_POS, 0, 17'd0));
        directed.push_back(eval_req(OP_POS, 0, 17'd65536));
        directed.push_back(eval_req(OP_POS, 0, 17'h1ffff));
        directed.push_back(eval_req(OP_TAN, 0, 17'd32768));
        directed.push_back(eval_req(OP_ACC, 0, 17'd0));
        directed.push_back(eval_req(OP_ACC, 0, 17'd65536));
        directed.push_back(with_result(node_write(63, 32'h00010000), '0, 1'b0));
        directed.push_back(with_result(node_write(62, 'x), '0, 1'b0));
        directed.push_back(with_result(eval_req(OP_POS, 63, 17'd100), '0, 1'b1));
        directed.push_back(eval_req(OP_ACC, 62, 17'd1));
        directed.push_back(eval_req(OP_TAN, 62, 17'd65535));
        directed.push_back(node_write(5, 'x));
        directed.push_back(node_write(6, 'x));
        directed.push_back(eval_req(OP_POS, 5, 17'd21845));
        directed.push_back(eval_req(OP_TAN, 5, 17'd1));
        directed.push_back(eval_req(OP_ACC, 5, 17'd65537));
        foreach (directed[n]) send_request(directed[n]);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 18 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 18 : 0;
            for (int n = 0; n < 150; n++)
            begin
                base = $urandom_range(0, 100) < 85 ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 63);
                if ($urandom_range(0, 99) < 30)
                    rq = node_write(base, 'x);
                else if ($urandom_range(0, 99) < 92 && base < 63 && tbl_valid[base]
                         && tbl_valid[base+1] || $urandom_range(0, 1))
                    rq = eval_req(op_t'($urandom_range(1, 3)), base,
                                  $urandom_range(0, 9) == 0
                                      ? 17'($urandom_range(65536, 131071))
                                      : 17'($urandom_range(0, 65536)));
                else
                    rq = eval_req(op_t'($urandom_range(1, 3)), base, 17'($urandom));
                send_request(rq);
                if (n == 75) wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("cubic_hermite_spline_eval regression: pass");
        else
            $display("cubic_hermite_spline_eval regression: fail");
        $finish;
    end
endmodule
